// ===== rtl/core/bss_pkg.sv =====
// Package for the sorted-table binary search block: field widths, command
// codes, controller states and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package bss_pkg;

  // Fixed widths of the word fields
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  // Search bounds: one bit of headroom each way for last below zero and
  // first past the top index, plus a sign bit
  localparam int unsigned BND_W = IDX_W + 2;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

  // Input word command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_EMIT
  } bss_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch key and bounds, read at the first midpoint
    logic wr;         // write one table entry
    logic step;       // narrow the bounds, read at the new midpoint
    logic res_set;    // capture the search outcome
    logic res_found;  // outcome to capture
    logic out_load;   // move the outcome into the output register
  } bss_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;      // incoming range has first above last
    logic hit;        // probed entry equals the key
    logic cont;       // bounds still hold after narrowing
  } bss_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/bss_dpath.sv =====
// Datapath of the sorted-table binary search: table memory, search bounds,
// probe compare and result registers. Depends on bss_pkg.
`default_nettype none

module bss_dpath
  import bss_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic                    clk_i,
  input  wire bss_ctl_t                ctl_i,
  output bss_sts_t                     sts_o,
  input  wire logic [IDX_W-1:0]        entry_index_i,
  input  wire logic signed [VAL_W-1:0] entry_value_i,
  input  wire logic signed [VAL_W-1:0] search_key_i,
  input  wire logic [IDX_W-1:0]        range_first_i,
  input  wire logic [IDX_W-1:0]        range_last_i,
  output logic                         found_o,
  output logic [IDX_W-1:0]             position_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned XW = (AW > IDX_W) ? AW : IDX_W;

  logic [VAL_W-1:0]        mem [TABLE_DEPTH];
  logic [VAL_W-1:0]        rd_data_q;
  logic                    rd_inr_q;

  logic signed [VAL_W-1:0] key_q;
  logic signed [BND_W-1:0] lo_q;
  logic signed [BND_W-1:0] hi_q;
  logic [IDX_W-1:0]        mid_q;

  logic                    res_found_q;
  logic [IDX_W-1:0]        res_pos_q;
  logic                    found_q;
  logic [IDX_W-1:0]        position_q;

  logic [XW-1:0]           wr_ext;
  logic [XW-1:0]           rd_ext;
  logic                    wr_inr;
  logic                    rd_inr;
  logic [IDX_W:0]          init_sum;
  logic [IDX_W-1:0]        init_mid;
  logic signed [VAL_W-1:0] val;
  logic signed [BND_W-1:0] mid_ext;
  logic signed [BND_W-1:0] nlo;
  logic signed [BND_W-1:0] nhi;
  logic signed [BND_W:0]   nsum;
  logic [IDX_W-1:0]        rd_idx;
  logic                    hit;
  logic                    key_lt;

  // Write port address
  assign wr_ext = XW'(entry_index_i);
  assign wr_inr = (32'(entry_index_i) < 32'(TABLE_DEPTH));

  // First midpoint straight from the incoming range
  assign init_sum = (IDX_W + 1)'(range_first_i) + (IDX_W + 1)'(range_last_i);
  assign init_mid = init_sum[IDX_W:1];

  // Probe compare; an index past the table reads as zero
  assign val    = rd_inr_q ? signed'(rd_data_q) : '0;
  assign hit    = (val == key_q);
  assign key_lt = (key_q < val);

  // Keep the lower half when the key sits below the probe, else the upper
  assign mid_ext = signed'(BND_W'(mid_q));
  always_comb begin
    nlo = lo_q;
    nhi = hi_q;
    if (key_lt) begin
      nhi = mid_ext - signed'(BND_W'(1));
    end else begin
      nlo = mid_ext + signed'(BND_W'(1));
    end
  end

  // Both bounds are non-negative whenever the search goes on
  assign nsum   = (BND_W + 1)'(nlo) + (BND_W + 1)'(nhi);
  assign rd_idx = ctl_i.load ? init_mid : nsum[IDX_W:1];
  assign rd_ext = XW'(rd_idx);
  assign rd_inr = (32'(rd_idx) < 32'(TABLE_DEPTH));

  assign sts_o.empty = (range_first_i > range_last_i);
  assign sts_o.hit   = hit;
  assign sts_o.cont  = (nlo <= nhi);

  // Single-port table, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && wr_inr) begin
      mem[wr_ext[AW-1:0]] <= entry_value_i;
    end
    if (ctl_i.load || ctl_i.step) begin
      rd_data_q <= mem[rd_ext[AW-1:0]];
      rd_inr_q  <= rd_inr;
    end
  end

  // Search bounds and probe index
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q <= search_key_i;
      lo_q  <= signed'(BND_W'(range_first_i));
      hi_q  <= signed'(BND_W'(range_last_i));
    end else if (ctl_i.step) begin
      lo_q <= nlo;
      hi_q <= nhi;
    end
    if (ctl_i.load || ctl_i.step) begin
      mid_q <= rd_idx;
    end
  end

  // Outcome, then the output word
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_set) begin
      res_found_q <= ctl_i.res_found;
      res_pos_q   <= ctl_i.res_found ? mid_q : '0;
    end
    if (ctl_i.out_load) begin
      found_q    <= res_found_q;
      position_q <= res_pos_q;
    end
  end

  assign found_o    = found_q;
  assign position_o = position_q;

endmodule

`default_nettype wire

// ===== rtl/core/bss_ctrl.sv =====
// Controller of the sorted-table binary search: accepts words, steps the
// probe loop and owns the output valid. Depends on bss_pkg.
`default_nettype none

module bss_ctrl
  import bss_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic     cmd_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire bss_sts_t sts_i,
  output bss_ctl_t      ctl_o
);

  bss_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == CMD_SEARCH)) begin
          state_d = sts_i.empty ? ST_EMIT : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts_i.hit || !sts_i.cont) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    ctl_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_WRITE) begin
            ctl_o.wr = 1'b1;
          end else if (sts_i.empty) begin
            ctl_o.res_set = 1'b1;
          end else begin
            ctl_o.load = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (sts_i.hit) begin
          ctl_o.res_set   = 1'b1;
          ctl_o.res_found = 1'b1;
        end else if (sts_i.cont) begin
          ctl_o.step = 1'b1;
        end else begin
          ctl_o.res_set = 1'b1;
        end
      end
      ST_EMIT: begin
        ctl_o.out_load = slot_free;
      end
      default: ctl_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/binary_search_sorted_table_top.sv =====
// Top level of the sorted-table binary search block: joins the controller
// and the datapath. Depends on bss_pkg, bss_ctrl and bss_dpath.
`default_nettype none

// A write word (cmd 0) stores entry_value at entry_index and gives no
// result; an index at or beyond TABLE_DEPTH is dropped. A search word
// (cmd 1) looks for search_key in the inclusive index range [range_first,
// range_last] of a table that software has loaded in ascending signed
// order, and gives exactly one result word: found, and the matching
// position (zero when not found). A search is accepted, probes the
// single-port table, then moves its outcome into the output register once
// the output side is free. It makes at most floor(log2(n)) + 1 probes
// for a range of n entries (11 probes for the full 1024-entry range).
// An empty range (first above last) makes no probe. The probe loop is set
// by the registered read of the table memory: each cycle compares the word
// read, narrows the bounds and issues the next read. The input side stalls
// while a search is in flight; the finished result waits in its own
// register, so the next word is taken while it is still unread.
// Entries never written hold unknown data; searches must not probe them.
module binary_search_sorted_table_top
  import bss_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Input channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    cmd_i,
  input  wire logic [IDX_W-1:0]        entry_index_i,
  input  wire logic signed [VAL_W-1:0] entry_value_i,
  input  wire logic signed [VAL_W-1:0] search_key_i,
  input  wire logic [IDX_W-1:0]        range_first_i,
  input  wire logic [IDX_W-1:0]        range_last_i,
  // Result channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         found_o,
  output logic [IDX_W-1:0]             position_o
);

  bss_ctl_t ctl;
  bss_sts_t sts;

  bss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  bss_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .found_o       (found_o),
    .position_o    (position_o)
  );

`ifndef ASSERT_OFF
  // An accepted search then holds the input side stalled
  a_search_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (cmd_i == CMD_SEARCH)) |=> in_stall_o)
    else $error("search accepted without holding the input side");

  // A miss always reports position zero
  a_miss_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (position_o == '0))
    else $error("not-found result with non-zero position");

  // A result word appears only from an output register load
  a_valid_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctl.out_load))
    else $error("result valid without an output load");

  // A table write never coincides with a bounds load or step in the same cycle
  a_no_load_and_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.wr && (ctl.load || ctl.step)))
    else $error("table write collides with a probe read");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sorted-table binary search block.
// Loads table words, fires searches and checks each result against an
// in-bench prediction. Depends on bss_pkg and binary_search_sorted_table_top.
`timescale 1ns / 100ps

module tb_top
  import bss_pkg::*;
();

  // Cycles with no word moving on either channel before giving up; room for
  // the slowest search and the longest random gaps on both sides.
  localparam int STUCK_LIMIT  = 4000;
  // Longest search plus headroom: let a stray result surface after the drain
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // One input word, every field carried whatever the command
  typedef struct {
    logic                    cmd;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] search_key;
    logic [IDX_W-1:0]        range_first;
    logic [IDX_W-1:0]        range_last;
  } bss_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } search_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    cmd_i;
  logic [IDX_W-1:0]        entry_index_i;
  logic signed [VAL_W-1:0] entry_value_i;
  logic signed [VAL_W-1:0] search_key_i;
  logic [IDX_W-1:0]        range_first_i;
  logic [IDX_W-1:0]        range_last_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    found_o;
  logic [IDX_W-1:0]        position_o;

  // Shadow copy of the table and a flag per entry that has been loaded;
  // the search generator never lets the block probe an unloaded entry
  bit signed [VAL_W-1:0] shadow_entries [DEFAULT_TABLE_DEPTH];
  bit                    entry_loaded   [DEFAULT_TABLE_DEPTH];

  search_result_t expected_results[$];

  int items_sent    = 0;
  int mismatches    = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 49;
  int stuck_cycles  = 0;

  binary_search_sorted_table_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Walk the probe sequence over the shadow table: the predicted outcome,
  // plus a flag telling whether any probe lands on an unloaded entry.
  function automatic void walk_search(input logic signed [VAL_W-1:0] key,
                                      input logic [IDX_W-1:0] first,
                                      input logic [IDX_W-1:0] last,
                                      output bit hit, output logic [IDX_W-1:0] pos,
                                      output bit blind);
    int lo, hi, mid;
    lo    = int'(first);
    hi    = int'(last);
    hit   = 1'b0;
    pos   = '0;
    blind = 1'b0;
    while (lo <= hi && !hit) begin
      mid = (lo + hi) / 2;
      if (!entry_loaded[IDX_W'(mid)]) blind = 1'b1;
      if (shadow_entries[IDX_W'(mid)] == key) begin
        hit = 1'b1;
        pos = IDX_W'(mid);
      end else if (key < shadow_entries[IDX_W'(mid)]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
  endfunction

  // Ascending value for an index: the index, top bit flipped, sits above
  // 22 free low bits, so any mix of loaded entries stays in signed order.
  function automatic logic signed [VAL_W-1:0] ramp_value(input logic [IDX_W-1:0] idx,
                                                          input logic [21:0] low);
    return {idx ^ 10'h200, low};
  endfunction

  function automatic bss_word_t random_word();
    bss_word_t w;
    w.cmd         = 1'($urandom_range(1));
    w.entry_index = IDX_W'($urandom);
    w.entry_value = $urandom;
    w.search_key  = $urandom;
    w.range_first = IDX_W'($urandom);
    w.range_last  = IDX_W'($urandom);
    return w;
  endfunction

  // Send one word. Entered and left at a falling edge; valid is left high
  // so back-to-back words see no bubble unless the idle draw asks for one.
  task automatic send_word(input bss_word_t w);
    bit             accepted;
    bit             hit, blind;
    logic [IDX_W-1:0] pos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= w.cmd;
    entry_index_i <= w.entry_index;
    entry_value_i <= w.entry_value;
    search_key_i  <= w.search_key;
    range_first_i <= w.range_first;
    range_last_i  <= w.range_last;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = !in_stall_o;
      @(negedge clk_i);
    end
    items_sent++;
    // Update the shadow in acceptance order: writes land before any later search
    if (w.cmd == CMD_WRITE) begin
      shadow_entries[w.entry_index] = w.entry_value;
      entry_loaded[w.entry_index]   = 1'b1;
    end else begin
      walk_search(w.search_key, w.range_first, w.range_last, hit, pos, blind);
      expected_results.push_back('{found: hit, position: pos});
    end
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] value);
    bss_word_t w;
    w             = random_word();
    w.cmd         = CMD_WRITE;
    w.entry_index = idx;
    w.entry_value = value;
    send_word(w);
  endtask

  task automatic search_range(input logic signed [VAL_W-1:0] key,
                              input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] last);
    bss_word_t w;
    w             = random_word();
    w.cmd         = CMD_SEARCH;
    w.search_key  = key;
    w.range_first = first;
    w.range_last  = last;
    send_word(w);
  endtask

  // Extreme values at the extreme indices, hits on the first and on a
  // later probe, and misses above, below and between entries.
  task automatic test_table_edges();
    write_entry(10'd0,    32'sh8000_0000);
    write_entry(10'd1023, 32'sh7fff_ffff);
    write_entry(10'd1,    ramp_value(10'd1, 22'($urandom)));
    write_entry(10'd511,  ramp_value(10'd511, 22'($urandom)));
    write_entry(10'd1022, ramp_value(10'd1022, 22'($urandom)));
    search_range(shadow_entries[511], 10'd0, 10'd1023);
    search_range(32'sh8000_0000, 10'd0, 10'd0);
    search_range(32'sh8000_0001, 10'd0, 10'd0);
    search_range(32'sh7fff_ffff, 10'd1023, 10'd1023);
    search_range(32'sh8000_0000, 10'd1023, 10'd1023);
    search_range(shadow_entries[1], 10'd0, 10'd1);
    search_range(32'sh7fff_ffff, 10'd1022, 10'd1023);
    search_range(shadow_entries[1022] + 1, 10'd1022, 10'd1023);
  endtask

  // First bound above the last: no probe, not found
  task automatic test_empty_ranges();
    search_range($urandom, 10'd1023, 10'd0);
    search_range($urandom, 10'd1, 10'd0);
    search_range($urandom, 10'd512, 10'd511);
  endtask

  // Break the order at the bottom of the table: a key that is present gets
  // steered away from it, then restore the order
  task automatic test_unsorted_table();
    write_entry(10'd0, 32'sh7fff_ffff);
    search_range(shadow_entries[1], 10'd0, 10'd1);
    search_range(32'sh7fff_ffff, 10'd0, 10'd1);
    write_entry(10'd0, 32'sh8000_0000);
  endtask

  // Mostly well-formed traffic: load a run of ascending entries, then search
  // inside it. Mixed in: stray unordered values, wide ranges whose probes
  // happen to fall on loaded entries, and empty ranges.
  task automatic test_random_searches(input int n_items);
    int               target, base, run_len, pick, tries, lo_i, hi_i, pick_idx;
    bit               hit, blind;
    logic [IDX_W-1:0] pos, first, last;
    logic signed [VAL_W-1:0] key;
    target = items_sent + n_items;
    while (items_sent < target) begin
      base    = $urandom_range(1023);
      run_len = ($urandom_range(99) < 85) ? $urandom_range(16, 1) : $urandom_range(96, 17);
      if (base + run_len > DEFAULT_TABLE_DEPTH) run_len = DEFAULT_TABLE_DEPTH - base;
      for (int i = base; i < base + run_len; i++) begin
        if ($urandom_range(11) == 0) write_entry(IDX_W'(i), $urandom);
        else write_entry(IDX_W'(i), ramp_value(IDX_W'(i), 22'($urandom)));
      end
      repeat ($urandom_range(8, 1)) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          first = IDX_W'($urandom_range(1023, 1));
          last  = IDX_W'($urandom_range(first - 1, 0));
          search_range($urandom, first, last);
        end else begin
          blind = 1'b1;
          if (pick < 30) begin
            for (tries = 0; tries < 8 && blind; tries++) begin
              first    = IDX_W'($urandom_range(1023));
              last     = IDX_W'($urandom_range(1023, first));
              pick_idx = $urandom_range(last, first);
              key      = entry_loaded[IDX_W'(pick_idx)] ? shadow_entries[IDX_W'(pick_idx)]
                                                        : $urandom;
              walk_search(key, first, last, hit, pos, blind);
            end
          end
          // Fall back to a sub-range of the run just loaded
          if (blind) begin
            lo_i  = $urandom_range(base + run_len - 1, base);
            hi_i  = $urandom_range(base + run_len - 1, lo_i);
            first = IDX_W'(lo_i);
            last  = IDX_W'(hi_i);
            key   = shadow_entries[IDX_W'($urandom_range(hi_i, lo_i))];
            pick  = $urandom_range(99);
            if (pick < 10) key = key + 1;
            else if (pick < 20) key = key - 1;
            else if (pick < 35) key = $urandom;
          end
          search_range(key, first, last);
        end
      end
    end
  endtask

  // Result side: sample at the rising edge, redraw the stall at the falling one
  initial begin
    search_result_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word: found=%0b position=%0d", found_o, position_o);
        end else begin
          want = expected_results.pop_front();
          if (found_o !== want.found || position_o !== want.position) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                       want.found, want.position, found_o, position_o);
          end
        end
      end
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: restart the count on every word moved on either channel
  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    // Hold every input at a known value through reset
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_WRITE;
    entry_index_i = '0;
    entry_value_i = '0;
    search_key_i  = '0;
    range_first_i = '0;
    range_last_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Sender idles 37 in 100, receiver 49 in 100
    test_table_edges();
    test_empty_ranges();
    test_unsorted_table();
    test_random_searches(330);

    // Swap the idle rates
    send_idle_pct = 49;
    recv_idle_pct = 37;
    test_random_searches(350);

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_searches(350);

    // Drop valid, drain the outstanding results, then watch for strays
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
